[src/vsrl_pkg.sv]
// Shared types and constants for the velocity setpoint ramp limiter.
`timescale 1ns / 1ps

package vsrl_pkg;

    localparam int VEL_W      = 24;
    localparam int TIME_W     = 32;
    localparam int CUR_W      = 16;
    localparam int RATE_W     = 18;
    localparam int LIMIT_W    = 15;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    // step = rate * elapsed / 1000 with elapsed <= 1000, so it never exceeds the rate
    localparam int STEP_W     = RATE_W;
    // current-limit reduction width: 14.4 * (2^15 - 1) < 2^19
    localparam int RED_W      = 20;

    localparam logic [RATE_W-1:0]  ACCEL_RATE_RST    = 18'd4096;
    localparam logic [RATE_W-1:0]  BRAKE_RATE_RST    = 18'd4096;
    localparam logic [LIMIT_W-1:0] CURRENT_LIMIT_RST = 15'd7680;

    // 72/5 = 14 + 2/5; the 2/5 part is (2x * 52429) >> 18, exact for 2x < 2^16
    localparam logic [RED_W-1:0] LIMIT_GAIN_INT = 20'd14;
    localparam logic [15:0]      DIV5_RECIP     = 16'd52429;
    localparam int               DIV5_SHIFT     = 18;

    typedef enum logic [CMD_W-1:0] {
        CMD_UPDATE = 2'd0,
        CMD_START  = 2'd1,
        CMD_STOP   = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_RATE    = 2'd0,
        CFG_BRAKE_RATE    = 2'd1,
        CFG_CURRENT_LIMIT = 2'd2
    } cfg_idx_t;

    // Item handed to the slew stage
    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic                    slew;       // primed update: ramp toward target
        logic                    limited;
        logic signed [VEL_W-1:0] target;
        logic [STEP_W-1:0]       accel_step;
        logic [STEP_W-1:0]       brake_step;
    } ramp_item_t;

endpackage

[src/velocity_setpoint_ramp_limiter.sv]
// Top level of the velocity setpoint ramp limiter: current limit, direction gate, slew.
//
//  channel | ports                                     | direction
//  --------+-------------------------------------------+----------
//  input   | s_valid/s_ready, s_cmd .. s_reverse_mode   | in
//  result  | m_valid/m_ready, m_commanded_velocity ...  | out
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data   | in
//
// Four register stages (input, multiply, reciprocal multiply, result); one item per cycle
// sustained while m_ready stays high.
// Time and primed state are tracked at the input stage; the velocity is the result register.
// Synchronous active-low reset clears state and configuration to defaults.
// A stalled result stalls stages behind it only as they fill; config writes are always taken.
`timescale 1ns / 1ps

module velocity_setpoint_ramp_limiter #(
    parameter int MAX_ELAPSED_MS = 100
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [vsrl_pkg::CMD_W-1:0]            s_cmd,
    input  logic [vsrl_pkg::TIME_W-1:0]           s_now_ms,
    input  logic signed [vsrl_pkg::VEL_W-1:0]     s_requested_velocity,
    input  logic signed [vsrl_pkg::CUR_W-1:0]     s_bus_current,
    input  logic                                  s_reverse_mode,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [vsrl_pkg::VEL_W-1:0]     m_commanded_velocity,
    output logic                                  m_current_limited,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [vsrl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vsrl_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import vsrl_pkg::*;

    localparam int EL_W     = $clog2(MAX_ELAPSED_MS + 1);
    localparam int PROD_W   = RATE_W + EL_W;
    // floor(p / 1000) = (p * ceil(2^k / 1000)) >> k, exact for p < 2^PROD_W
    localparam int RECIP_SH = PROD_W + 10;
    localparam int RECIP_W  = RECIP_SH - 9;
    localparam int RPROD_W  = PROD_W + RECIP_W;
    localparam longint unsigned RECIP_VAL = ((64'd1 << RECIP_SH) + 64'd999) / 64'd1000;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    // configuration
    logic [RATE_W-1:0]  accel_rate_reg;
    logic [RATE_W-1:0]  brake_rate_reg;
    logic [LIMIT_W-1:0] current_limit_reg;

    // timing state tracked at the input
    logic [TIME_W-1:0]  last_time_reg;
    logic               primed_reg;

    // stage 1
    logic                    s1_valid_reg;
    logic [CMD_W-1:0]        s1_cmd_reg;
    logic                    s1_slew_reg;
    logic                    s1_limited_reg;
    logic [LIMIT_W-1:0]      s1_excess_reg;
    logic signed [VEL_W-1:0] s1_req_reg;
    logic                    s1_rev_reg;
    logic [EL_W-1:0]         s1_el_reg;

    // stage 2
    logic                    s2_valid_reg;
    logic [CMD_W-1:0]        s2_cmd_reg;
    logic                    s2_slew_reg;
    logic                    s2_limited_reg;
    logic [LIMIT_W-1:0]      s2_excess_reg;
    logic [31:0]             s2_div5_prod_reg;
    logic signed [VEL_W-1:0] s2_req_reg;
    logic                    s2_rev_reg;
    logic [PROD_W-1:0]       s2_accel_prod_reg;
    logic [PROD_W-1:0]       s2_brake_prod_reg;

    // stage 3
    logic                    s3_valid_reg;
    ramp_item_t              s3_item_reg;
    ramp_item_t              s3_item_next;

    // result
    logic                    m_valid_reg;
    logic signed [VEL_W-1:0] vel_reg;
    logic signed [VEL_W-1:0] vel_next;
    logic                    limited_reg;

    logic en1, en2, en3, out_en, ld_out, s_accept;

    logic [TIME_W-1:0]       elapsed_raw;
    logic [EL_W-1:0]         el_capped;
    logic                    over_limit;
    logic signed [CUR_W-1:0] excess_full;

    logic [RED_W-1:0]        red;
    logic [VEL_W-1:0]        req_mag;
    logic [VEL_W:0]          cut;
    logic [VEL_W-1:0]        reduced_mag;
    logic signed [VEL_W-1:0] limited_req;
    logic signed [VEL_W-1:0] gated_req;
    logic [RPROD_W-1:0]      accel_rprod;
    logic [RPROD_W-1:0]      brake_rprod;

    // flow control
    assign out_en   = !m_valid_reg || m_ready;
    assign en3      = !s3_valid_reg || out_en;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign ld_out   = s3_valid_reg && out_en;
    assign s_ready  = en1;
    assign s_accept = s_valid && en1;

    assign cfg_ready = 1'b1;

    assign m_valid              = m_valid_reg;
    assign m_commanded_velocity = vel_reg;
    assign m_current_limited    = limited_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_rate_reg    <= ACCEL_RATE_RST;
            brake_rate_reg    <= BRAKE_RATE_RST;
            current_limit_reg <= CURRENT_LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ACCEL_RATE:    accel_rate_reg    <= cfg_data[RATE_W-1:0];
                CFG_BRAKE_RATE:    brake_rate_reg    <= cfg_data[RATE_W-1:0];
                CFG_CURRENT_LIMIT: current_limit_reg <= cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // stage 1 input logic
    always_comb begin
        elapsed_raw = s_now_ms - last_time_reg;
        el_capped   = (elapsed_raw > TIME_W'(MAX_ELAPSED_MS)) ? EL_W'(MAX_ELAPSED_MS)
                                                              : EL_W'(elapsed_raw);
        over_limit  = s_bus_current > $signed({1'b0, current_limit_reg});
        excess_full = s_bus_current - $signed({1'b0, current_limit_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
            primed_reg    <= 1'b0;
        end else if (s_accept) begin
            unique case (s_cmd)
                CMD_UPDATE, CMD_START: begin
                    last_time_reg <= s_now_ms;
                    primed_reg    <= 1'b1;
                end
                CMD_STOP: begin
                    last_time_reg <= '0;
                    primed_reg    <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en1) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_cmd_reg     <= s_cmd;
            s1_slew_reg    <= primed_reg;
            s1_limited_reg <= (s_cmd == CMD_UPDATE) && over_limit;
            s1_excess_reg  <= excess_full[LIMIT_W-1:0];
            s1_req_reg     <= s_requested_velocity;
            s1_rev_reg     <= s_reverse_mode;
            s1_el_reg      <= el_capped;
        end
    end

    // stage 2: products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_cmd_reg        <= s1_cmd_reg;
            s2_slew_reg       <= s1_slew_reg;
            s2_limited_reg    <= s1_limited_reg;
            s2_excess_reg     <= s1_excess_reg;
            s2_div5_prod_reg  <= 32'({s1_excess_reg, 1'b0}) * 32'(DIV5_RECIP);
            s2_req_reg        <= s1_req_reg;
            s2_rev_reg        <= s1_rev_reg;
            s2_accel_prod_reg <= PROD_W'(accel_rate_reg) * PROD_W'(s1_el_reg);
            s2_brake_prod_reg <= PROD_W'(brake_rate_reg) * PROD_W'(s1_el_reg);
        end
    end

    // stage 3: current limit, direction gate, step limits
    always_comb begin
        red = RED_W'(s2_excess_reg) * LIMIT_GAIN_INT
            + RED_W'(s2_div5_prod_reg >> DIV5_SHIFT);

        req_mag     = s2_req_reg[VEL_W-1] ? VEL_W'(-s2_req_reg) : VEL_W'(s2_req_reg);
        cut         = {1'b0, req_mag} - (VEL_W+1)'(red);
        reduced_mag = cut[VEL_W] ? '0 : cut[VEL_W-1:0];

        if (s2_limited_reg) begin
            limited_req = s2_req_reg[VEL_W-1] ? -$signed(reduced_mag) : $signed(reduced_mag);
        end else begin
            limited_req = s2_req_reg;
        end

        if ((s2_rev_reg && limited_req > 0) || (!s2_rev_reg && limited_req < 0)) begin
            gated_req = '0;
        end else begin
            gated_req = limited_req;
        end

        accel_rprod = RPROD_W'(s2_accel_prod_reg) * RPROD_W'(RECIP);
        brake_rprod = RPROD_W'(s2_brake_prod_reg) * RPROD_W'(RECIP);

        s3_item_next.cmd        = s2_cmd_reg;
        s3_item_next.slew       = s2_slew_reg;
        s3_item_next.limited    = s2_limited_reg;
        s3_item_next.target     = gated_req;
        s3_item_next.accel_step = STEP_W'(accel_rprod >> RECIP_SH);
        s3_item_next.brake_step = STEP_W'(brake_rprod >> RECIP_SH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en3) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            s3_item_reg <= s3_item_next;
        end
    end

    // result stage: the commanded velocity register is the ramp state
    vsrl_slew u_slew (
        .item     (s3_item_reg),
        .held     (vel_reg),
        .next_vel (vel_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            vel_reg     <= '0;
            limited_reg <= 1'b0;
        end else begin
            if (out_en) begin
                m_valid_reg <= s3_valid_reg;
            end
            if (ld_out) begin
                vel_reg     <= vel_next;
                limited_reg <= s3_item_reg.limited;
            end
        end
    end

    // input backpressure only comes from a full pipe behind a stalled result
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without a stalled result");

    a_start_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (ld_out && (s3_item_reg.cmd == CMD_START || s3_item_reg.cmd == CMD_STOP))
        |=> (vel_reg == '0))
        else $error("start/stop transaction did not zero the velocity");

    a_vel_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ld_out |=> $stable(vel_reg))
        else $error("velocity changed without a result transaction");

    a_priming_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ld_out && s3_item_reg.cmd == CMD_UPDATE && !s3_item_reg.slew) |=> $stable(vel_reg))
        else $error("priming update moved the velocity");

endmodule

[src/vsrl_slew.sv]
// Slew step: moves the held velocity toward the target by at most one step; start and stop zero it.
`timescale 1ns / 1ps

module vsrl_slew (
    input  vsrl_pkg::ramp_item_t               item,
    input  logic signed [vsrl_pkg::VEL_W-1:0]  held,
    output logic signed [vsrl_pkg::VEL_W-1:0]  next_vel
);
    import vsrl_pkg::*;

    logic                    opposite;
    logic signed [VEL_W-1:0] tgt;
    logic [VEL_W-1:0]        tgt_mag;
    logic [VEL_W-1:0]        held_mag;
    logic [STEP_W-1:0]       step;
    logic signed [VEL_W:0]   diff;
    logic [VEL_W:0]          diff_mag;
    logic signed [VEL_W:0]   step_s;
    logic signed [VEL_W:0]   moved;
    logic signed [VEL_W-1:0] slewed;

    always_comb begin
        // a request against the held direction ramps down to zero first
        opposite = (held < 0 && item.target > 0) || (held > 0 && item.target < 0);
        tgt      = opposite ? '0 : item.target;
        tgt_mag  = tgt[VEL_W-1] ? VEL_W'(-tgt) : VEL_W'(tgt);
        held_mag = held[VEL_W-1] ? VEL_W'(-held) : VEL_W'(held);
        step     = (tgt_mag > held_mag) ? item.accel_step : item.brake_step;

        diff     = (VEL_W+1)'(tgt) - (VEL_W+1)'(held);
        diff_mag = diff[VEL_W] ? (VEL_W+1)'(-diff) : (VEL_W+1)'(diff);
        step_s   = $signed((VEL_W+1)'(step));
        moved    = (VEL_W+1)'(held) + (diff[VEL_W] ? -step_s : step_s);

        if (diff_mag <= (VEL_W+1)'(step)) begin
            slewed = tgt;
        end else begin
            slewed = VEL_W'(moved);
        end

        unique case (item.cmd)
            CMD_UPDATE: begin
                next_vel = item.slew ? slewed : held;
            end
            CMD_START, CMD_STOP: begin
                next_vel = '0;
            end
            default: begin
                next_vel = held;
            end
        endcase
    end

endmodule

[tb/tb.sv]
// Self-checking testbench for the velocity setpoint ramp limiter.
`timescale 1ns / 1ps

module tb;
    import vsrl_pkg::*;

    localparam int          MAX_ELAPSED_MS = 100;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam logic [1:0]  CFG_RESERVED   = 2'd3;
    localparam logic [RATE_W-1:0] RATE_MAX = 18'd262143;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = 15'd32767;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic [TIME_W-1:0]       now;
        logic signed [VEL_W-1:0] req;
        logic signed [CUR_W-1:0] cur;
        logic                    rev;
    } setpoint_req_t;

    typedef struct {
        logic signed [VEL_W-1:0] vel;
        logic                    limited;
    } setpoint_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [CMD_W-1:0]        s_cmd = '0;
    logic [TIME_W-1:0]       s_now_ms = '0;
    logic signed [VEL_W-1:0] s_requested_velocity = '0;
    logic signed [CUR_W-1:0] s_bus_current = '0;
    logic                    s_reverse_mode = 1'b0;

    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [VEL_W-1:0] m_commanded_velocity;
    logic                    m_current_limited;

    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    // predictor state and its copy of the registers
    logic [RATE_W-1:0]       accel_rate_q = ACCEL_RATE_RST;
    logic [RATE_W-1:0]       brake_rate_q = BRAKE_RATE_RST;
    logic [LIMIT_W-1:0]      cur_limit_q  = CURRENT_LIMIT_RST;
    logic signed [VEL_W-1:0] held_vel = '0;
    logic [TIME_W-1:0]       last_ms = '0;
    logic                    primed = 1'b0;

    setpoint_out_t setpoints_expected[$];

    logic idle_in  = 1'b1;
    logic idle_out = 1'b1;

    int n_items = 0;
    int n_results = 0;
    int n_limited = 0;
    int n_reg_writes = 0;
    int n_errors = 0;

    velocity_setpoint_ramp_limiter #(
        .MAX_ELAPSED_MS(MAX_ELAPSED_MS)
    ) DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_cmd                (s_cmd),
        .s_now_ms             (s_now_ms),
        .s_requested_velocity (s_requested_velocity),
        .s_bus_current        (s_bus_current),
        .s_reverse_mode       (s_reverse_mode),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_commanded_velocity (m_commanded_velocity),
        .m_current_limited    (m_current_limited),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic longint abs_val(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Next commanded velocity for one accepted transaction
    task automatic predict_setpoint(input setpoint_req_t it);
        longint req, held, target, diff, step, red, m;
        logic [TIME_W-1:0] elapsed;
        logic [RATE_W-1:0] rate;
        logic              limited;
        setpoint_out_t     exp_out;
        limited = 1'b0;
        case (it.cmd)
            CMD_START: begin
                held_vel = '0;
                last_ms  = it.now;
                primed   = 1'b1;
            end
            CMD_STOP: begin
                held_vel = '0;
                last_ms  = '0;
                primed   = 1'b0;
            end
            CMD_UPDATE: begin
                req = it.req;
                if (longint'(it.cur) > longint'(cur_limit_q)) begin
                    // 14.4 velocity LSB per current LSB over the limit
                    red = ((longint'(it.cur) - longint'(cur_limit_q)) * 72) / 5;
                    m = abs_val(req) - red;
                    if (m < 0) m = 0;
                    req = (req < 0) ? -m : m;
                    limited = 1'b1;
                end
                if (it.rev && req > 0) req = 0;
                else if (!it.rev && req < 0) req = 0;

                if (!primed) begin
                    primed  = 1'b1;
                    last_ms = it.now;
                end else begin
                    elapsed = it.now - last_ms;
                    last_ms = it.now;
                    if (elapsed > TIME_W'(MAX_ELAPSED_MS)) elapsed = TIME_W'(MAX_ELAPSED_MS);
                    held   = held_vel;
                    target = req;
                    // opposite sign: ramp to zero first
                    if ((held < 0 && target > 0) || (held > 0 && target < 0)) target = 0;
                    rate = (abs_val(target) > abs_val(held)) ? accel_rate_q : brake_rate_q;
                    step = (longint'(rate) * longint'(elapsed)) / 1000;
                    diff = target - held;
                    if (abs_val(diff) <= step) held = target;
                    else held += (diff < 0) ? -step : step;
                    held_vel = held[VEL_W-1:0];
                end
            end
            default: ;
        endcase
        exp_out.vel     = held_vel;
        exp_out.limited = limited;
        if (limited) n_limited++;
        setpoints_expected = {setpoints_expected, exp_out};
    endtask

    task automatic send_setpoint(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now,
                                 input logic signed [VEL_W-1:0] req,
                                 input logic signed [CUR_W-1:0] cur, input logic rev);
        int gap;
        setpoint_req_t it;
        it = '{cmd, now, req, cur, rev};
        gap = idle_in ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid              <= 1'b1;
        s_cmd                <= cmd;
        s_now_ms             <= now;
        s_requested_velocity <= req;
        s_bus_current        <= cur;
        s_reverse_mode       <= rev;
        do @(posedge aclk); while (!s_ready);
        predict_setpoint(it);
        n_items++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ACCEL_RATE:    accel_rate_q = data[RATE_W-1:0];
            CFG_BRAKE_RATE:    brake_rate_q = data[RATE_W-1:0];
            CFG_CURRENT_LIMIT: cur_limit_q  = data[LIMIT_W-1:0];
            default: ;
        endcase
        n_reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait for every outstanding result, then let the pipeline settle
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (setpoints_expected.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Result side: random stalls on m_ready, compare each transaction
    initial begin : result_checker
        int stall;
        setpoint_out_t exp_out;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = idle_out ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            n_results++;
            if (setpoints_expected.size() == 0) begin
                $error("unexpected result: commanded_velocity %0d", m_commanded_velocity);
                n_errors++;
            end else begin
                exp_out = setpoints_expected.pop_front();
                if (m_commanded_velocity !== exp_out.vel) begin
                    $error("commanded_velocity: expected %0d, actual %0d",
                           exp_out.vel, m_commanded_velocity);
                    n_errors++;
                end
                if (m_current_limited !== exp_out.limited) begin
                    $error("current_limited: expected %0b, actual %0b",
                           exp_out.limited, m_current_limited);
                    n_errors++;
                end
            end
        end
    end

    task automatic test_priming_and_ramp();
        idle_in  = 1'b0;
        idle_out = 1'b0;
        send_setpoint(CMD_UPDATE, 32'd1000, 24'sd50000, 16'sd0, 1'b0);   // primes only
        send_setpoint(CMD_UPDATE, 32'd1100, 24'sd8388607, 16'sd0, 1'b0);
        send_setpoint(CMD_UPDATE, 32'd1100, 24'sd8388607, 16'sd0, 1'b0); // no time passed
        send_setpoint(CMD_UPDATE, 32'd1095, 24'sd8388607, 16'sd0, 1'b0); // time went back
        send_setpoint(CMD_UPDATE, 32'd1145, 24'sd100, 16'sd0, 1'b0);
        send_setpoint(CMD_UPDATE, 32'd1245, 24'sd600, 16'sd0, 1'b0);     // within one step
    endtask

    task automatic test_direction_gate();
        idle_in = 1'b1;
        send_setpoint(CMD_UPDATE, 32'd1300, -24'sd8388608, 16'sd0, 1'b0);
        send_setpoint(CMD_UPDATE, 32'd1400, 24'sd900, 16'sd0, 1'b0);
        send_setpoint(CMD_UPDATE, 32'd1500, -24'sd5000, 16'sd0, 1'b1);   // sign flip
        send_setpoint(CMD_UPDATE, 32'd1600, -24'sd5000, 16'sd0, 1'b1);
        send_setpoint(CMD_UPDATE, 32'd1700, 24'sd5000, 16'sd0, 1'b1);
    endtask

    task automatic test_current_limit();
        idle_out = 1'b1;
        send_setpoint(CMD_UPDATE, 32'd1800, -24'sd8388608, 16'sd32767, 1'b1);
        send_setpoint(CMD_UPDATE, 32'd1900, -24'sd3000, 16'sd7681, 1'b1);
        send_setpoint(CMD_UPDATE, 32'd2000, -24'sd3000, 16'sd7680, 1'b1);
        send_setpoint(CMD_UPDATE, 32'd2100, 24'sd3000, -16'sd32768, 1'b0);
    endtask

    task automatic test_commands();
        send_setpoint(CMD_STOP, 32'hFFFF_FFFF, 24'sd8388607, 16'sd32767, 1'b1);
        send_setpoint(CMD_UPDATE, 32'd0, 24'sd1000, 16'sd32767, 1'b0); // priming, limited
        send_setpoint(CMD_START, 32'hFFFF_FFC0, -24'sd1, 16'sd0, 1'b1);
        send_setpoint(CMD_UPDATE, 32'h0000_0010, -24'sd4000, 16'sd0, 1'b1); // clock wraps
        send_setpoint(CMD_UNUSED, 32'd5, 24'sd8388607, 16'sd32767, 1'b0);
        send_setpoint(CMD_UPDATE, 32'd60, -24'sd4000, 16'sd0, 1'b1);
    endtask

    task automatic test_config_extremes();
        drain_pipeline();
        write_reg(CFG_ACCEL_RATE, RATE_MAX);
        write_reg(CFG_BRAKE_RATE, 18'd1);
        write_reg(CFG_CURRENT_LIMIT, '0);
        write_reg(CFG_RESERVED, 18'h3FFFF);  // no register there
        send_setpoint(CMD_START, 32'd5000, 24'sd0, 16'sd0, 1'b0);
        send_setpoint(CMD_UPDATE, 32'd5100, 24'sd8388607, 16'sd0, 1'b0);
        send_setpoint(CMD_UPDATE, 32'd5200, 24'sd10, 16'sd0, 1'b0);
        send_setpoint(CMD_UPDATE, 32'd5300, 24'sd20000, 16'sd1, 1'b0);
        drain_pipeline();
        write_reg(CFG_ACCEL_RATE, 18'd1);
        write_reg(CFG_BRAKE_RATE, RATE_MAX);
        write_reg(CFG_CURRENT_LIMIT, 18'(LIMIT_MAX));
        send_setpoint(CMD_UPDATE, 32'd5400, 24'sd8388607, 16'sd32767, 1'b0);
        send_setpoint(CMD_UPDATE, 32'd5500, 24'sd0, 16'sd0, 1'b0);
        drain_pipeline();
    endtask

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 4))
            0:       return 18'd1;
            1:       return RATE_MAX;
            2:       return RATE_W'($urandom_range(1, 262143));
            default: return RATE_W'($urandom_range(1000, 40000));
        endcase
    endfunction

    // Mostly start-then-update sequences with advancing time, plus noise
    task automatic test_random_traffic(input int count, input logic [TIME_W-1:0] base);
        logic [TIME_W-1:0]       t_now;
        logic signed [VEL_W-1:0] req;
        logic signed [CUR_W-1:0] cur;
        logic [CFG_DATA_W-1:0]   lim_data;
        logic [CMD_W-1:0]        cmd;
        logic                    rev;
        int                      r, mag_v, lim;
        drain_pipeline();
        write_reg(CFG_ACCEL_RATE, pick_rate());
        write_reg(CFG_BRAKE_RATE, pick_rate());
        case ($urandom_range(0, 3))
            0:       lim_data = '0;
            1:       lim_data = 18'(LIMIT_MAX);
            default: lim_data = 18'($urandom_range(0, 32767));
        endcase
        // bits above the register width are don't-care
        lim_data[CFG_DATA_W-1:LIMIT_W] = 3'($urandom_range(0, 7));
        write_reg(CFG_CURRENT_LIMIT, lim_data);
        lim   = int'(cur_limit_q);
        t_now = base;
        rev   = 1'($urandom_range(0, 1));
        send_setpoint(CMD_START, t_now, '0, '0, rev);
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0) begin
                idle_in  = 1'($urandom_range(0, 1));
                idle_out = 1'($urandom_range(0, 1));
            end
            r = $urandom_range(0, 99);
            if (r < 3) cmd = CMD_STOP;
            else if (r < 6) cmd = CMD_START;
            else if (r < 8) cmd = CMD_UNUSED;
            else cmd = CMD_UPDATE;

            if ($urandom_range(0, 99) < 3) t_now = $urandom;
            else t_now += $urandom_range(0, 120);

            if ($urandom_range(0, 19) == 0) rev = ~rev;

            case ($urandom_range(0, 9))
                0, 1, 2, 3: mag_v = $urandom_range(0, 2000);
                4, 5, 6, 7: mag_v = $urandom_range(0, 100000);
                default:    mag_v = -1;
            endcase
            if (mag_v < 0) req = VEL_W'($urandom);
            else if ($urandom_range(0, 9) < 8) req = VEL_W'(rev ? -mag_v : mag_v);
            else req = VEL_W'(rev ? mag_v : -mag_v);

            r = $urandom_range(0, 99);
            if (r < 75) cur = CUR_W'($urandom_range(0, lim));
            else if (r < 92) cur = CUR_W'((lim + 600 > 32767) ? 32767
                                                               : lim + $urandom_range(1, 600));
            else cur = CUR_W'($urandom);

            send_setpoint(cmd, t_now, req, cur, rev);
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_priming_and_ramp();
        test_direction_gate();
        test_current_limit();
        test_commands();
        test_config_extremes();
        test_random_traffic(220, $urandom);
        test_random_traffic(220, 32'hFFFF_F000);
        test_random_traffic(220, $urandom);
        test_random_traffic(220, 32'd0);
        test_random_traffic(220, $urandom);
        test_random_traffic(220, $urandom);
        drain_pipeline();

        $display("Run covered %0d setpoint transactions (%0d current-limited)",
                 n_items, n_limited);
        $display("under %0d register writes, with %0d results compared and %0d mismatches.",
                 n_reg_writes, n_results, n_errors);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
